/* rtl/dstd_pkg.sv */
// ----------------------------------------------------------------------------
// dstd_pkg
// Shared types and constants for the data stall timeout detector.
// ----------------------------------------------------------------------------
package dstd_pkg;

  localparam int SampleW  = 32;
  localparam int HoursW   = 5;
  localparam int MinutesW = 6;
  localparam int SecondsW = 6;
  localparam int MicrosW  = 20;

  localparam int SecsPerMin  = 60;
  localparam int SecsPerHour = 3600;

  // Signed seconds difference: at most 31*3600 + 63*60 + 63 in magnitude.
  localparam int ElapsedW = 18;
  localparam int SecsW    = ElapsedW - 1;
  // Signed microsecond difference with room for the unsigned limit.
  localparam int MicroDiffW = MicrosW + 2;

  localparam int CfgDataW = 32;
  localparam int CfgAddrW = 4;

  typedef enum logic [1:0] {
    RegLimitHours   = 2'd0,
    RegLimitMinutes = 2'd1,
    RegLimitSeconds = 2'd2,
    RegLimitMicros  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [HoursW-1:0]   hours;
    logic [MinutesW-1:0] minutes;
    logic [SecondsW-1:0] seconds;
    logic [MicrosW-1:0]  micros;
  } time_t;

  typedef struct packed {
    logic [SampleW-1:0] sample_value;
    time_t              now;
  } item_t;

  typedef struct packed {
    logic changed;
    logic arm;
    logic fire;
  } decision_t;

endpackage

/* rtl/dstd_if.sv */
// ----------------------------------------------------------------------------
// dstd_if
// Valid/ready channels for time-stamped samples and detector results.
// ----------------------------------------------------------------------------
interface dstd_in_if;
  logic                                valid;
  logic                                ready;
  logic [dstd_pkg::SampleW-1:0]        sample_value;
  logic [dstd_pkg::HoursW-1:0]         now_hours;
  logic [dstd_pkg::MinutesW-1:0]       now_minutes;
  logic [dstd_pkg::SecondsW-1:0]       now_seconds;
  logic [dstd_pkg::MicrosW-1:0]        now_micros;

  modport source (
    output valid, sample_value, now_hours, now_minutes, now_seconds, now_micros,
    input  ready
  );
  modport sink (
    input  valid, sample_value, now_hours, now_minutes, now_seconds, now_micros,
    output ready
  );
endinterface

interface dstd_out_if;
  logic valid;
  logic ready;
  logic timed_out;
  logic toggle_bit;

  modport source (output valid, timed_out, toggle_bit, input ready);
  modport sink (input valid, timed_out, toggle_bit, output ready);
endinterface

/* rtl/dstd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// dstd_cfg_regs
// APB register bank holding the four parts of the stall timeout limit.
// ----------------------------------------------------------------------------
module dstd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dstd_pkg::CfgAddrW-1:0]    paddr,
  input  logic [dstd_pkg::CfgDataW-1:0]    pwdata,
  output logic [dstd_pkg::CfgDataW-1:0]    prdata,
  output logic                             pready,
  output dstd_pkg::time_t                  limit
);

  dstd_pkg::time_t   limit_r;
  dstd_pkg::time_t   limit_nxt;
  dstd_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = dstd_pkg::reg_idx_t'(paddr[dstd_pkg::CfgAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign limit  = limit_r;

  always_comb begin
    limit_nxt = limit_r;
    if (wr_en) begin
      case (idx)
        dstd_pkg::RegLimitHours:   limit_nxt.hours   = pwdata[dstd_pkg::HoursW-1:0];
        dstd_pkg::RegLimitMinutes: limit_nxt.minutes = pwdata[dstd_pkg::MinutesW-1:0];
        dstd_pkg::RegLimitSeconds: limit_nxt.seconds = pwdata[dstd_pkg::SecondsW-1:0];
        dstd_pkg::RegLimitMicros:  limit_nxt.micros  = pwdata[dstd_pkg::MicrosW-1:0];
        default:                   limit_nxt = limit_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dstd_pkg::RegLimitHours:   prdata = dstd_pkg::CfgDataW'(limit_r.hours);
      dstd_pkg::RegLimitMinutes: prdata = dstd_pkg::CfgDataW'(limit_r.minutes);
      dstd_pkg::RegLimitSeconds: prdata = dstd_pkg::CfgDataW'(limit_r.seconds);
      dstd_pkg::RegLimitMicros:  prdata = dstd_pkg::CfgDataW'(limit_r.micros);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '{hours: '0, minutes: '0, seconds: dstd_pkg::SecondsW'(1), micros: '0};
    end else begin
      limit_r <= limit_nxt;
    end
  end

endmodule

/* rtl/dstd_eval.sv */
// ----------------------------------------------------------------------------
// dstd_eval
// Decides for one sample whether it changes the value, arms, or times out.
// ----------------------------------------------------------------------------
module dstd_eval #(
  parameter int HELD_W = 32
) (
  input  logic [HELD_W-1:0]   sample,
  input  dstd_pkg::time_t     now,
  input  logic [HELD_W-1:0]   held,
  input  logic                armed,
  input  dstd_pkg::time_t     start,
  input  dstd_pkg::time_t     limit,
  output dstd_pkg::decision_t dec
);

  localparam int EW = dstd_pkg::ElapsedW;
  localparam int SW = dstd_pkg::SecsW;
  localparam int UW = dstd_pkg::MicroDiffW;

  logic signed [dstd_pkg::HoursW:0]   dh;
  logic signed [dstd_pkg::MinutesW:0] dm;
  logic signed [dstd_pkg::SecondsW:0] ds;
  logic signed [EW-1:0]               elapsed;
  logic [SW-1:0]                      elapsed_abs;
  logic [SW-1:0]                      lim_secs;
  logic signed [UW-1:0]               du;
  logic signed [UW-1:0]               lim_us;
  logic                               over;

  assign dh = $signed({1'b0, now.hours})   - $signed({1'b0, start.hours});
  assign dm = $signed({1'b0, now.minutes}) - $signed({1'b0, start.minutes});
  assign ds = $signed({1'b0, now.seconds}) - $signed({1'b0, start.seconds});

  assign elapsed = EW'(ds)
                 + EW'(dm) * EW'(dstd_pkg::SecsPerMin)
                 + EW'(dh) * EW'(dstd_pkg::SecsPerHour);

  // Time stamps earlier than the start count as elapsed time as well.
  assign elapsed_abs = elapsed[EW-1] ? SW'(-elapsed) : SW'(elapsed);

  assign lim_secs = SW'(limit.seconds)
                  + SW'(limit.minutes) * SW'(dstd_pkg::SecsPerMin)
                  + SW'(limit.hours) * SW'(dstd_pkg::SecsPerHour);

  assign du     = $signed({2'b00, now.micros}) - $signed({2'b00, start.micros});
  assign lim_us = $signed({2'b00, limit.micros});

  assign over = (elapsed_abs > lim_secs) || ((elapsed_abs == lim_secs) && (du >= lim_us));

  assign dec.changed = (sample != held);
  assign dec.arm     = !dec.changed && !armed;
  assign dec.fire    = !dec.changed && armed && over;

endmodule

/* rtl/data_stall_timeout_detector_core.sv */
// ----------------------------------------------------------------------------
// data_stall_timeout_detector_core
// Flags a monitored value that has stayed unchanged for longer than a limit.
// ----------------------------------------------------------------------------
// Each sample transaction yields exactly one result transaction. A sample is
// registered on acceptance, evaluated against the held value and start time
// once the result register is free or drains, and written to the result
// register; one sample can be taken every clock while the result side keeps
// up. The single evaluation stage, which also updates the detector state,
// sets that rate. timed_out is high on the sample that crossed the limit and
// toggle_bit inverts on every timeout. The limit registers reset to one
// second and should be written only while no transaction is in flight.
module data_stall_timeout_detector_core #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  dstd_in_if.sink                       in_if,
  dstd_out_if.source                    out_if,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [dstd_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [dstd_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [dstd_pkg::CfgDataW-1:0] cfg_prdata,
  output logic                          cfg_pready
);

  localparam int HeldW = (DATA_WIDTH < dstd_pkg::SampleW) ? DATA_WIDTH : dstd_pkg::SampleW;

  dstd_pkg::time_t     limit;
  dstd_pkg::decision_t dec;

  logic                s1_valid_r;
  logic                s1_valid_nxt;
  dstd_pkg::item_t     s1_item_r;
  logic                s1_go;

  logic [HeldW-1:0]    held_r;
  logic [HeldW-1:0]    held_nxt;
  logic                armed_r;
  logic                armed_nxt;
  dstd_pkg::time_t     start_r;
  dstd_pkg::time_t     start_nxt;
  logic                flip_r;
  logic                flip_nxt;

  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                out_timed_out_r;
  logic                out_timed_out_nxt;

  dstd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .limit   (limit)
  );

  dstd_eval #(
    .HELD_W (HeldW)
  ) u_eval (
    .sample (s1_item_r.sample_value[HeldW-1:0]),
    .now    (s1_item_r.now),
    .held   (held_r),
    .armed  (armed_r),
    .start  (start_r),
    .limit  (limit),
    .dec    (dec)
  );

  // The evaluation stage moves whenever the result register is free or drains.
  assign s1_go       = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_go;

  assign out_if.valid      = out_valid_r;
  assign out_if.timed_out  = out_timed_out_r;
  assign out_if.toggle_bit = flip_r;

  always_comb begin
    s1_valid_nxt = in_if.ready ? in_if.valid : s1_valid_r;
    held_nxt          = held_r;
    armed_nxt         = armed_r;
    start_nxt         = start_r;
    flip_nxt          = flip_r;
    out_timed_out_nxt = out_timed_out_r;
    out_valid_nxt     = out_valid_r && !out_if.ready;
    if (s1_go) begin
      out_valid_nxt     = 1'b1;
      out_timed_out_nxt = dec.fire;
      if (dec.changed) begin
        held_nxt  = s1_item_r.sample_value[HeldW-1:0];
        armed_nxt = 1'b0;
      end else if (dec.arm) begin
        armed_nxt = 1'b1;
        start_nxt = s1_item_r.now;
      end else if (dec.fire) begin
        armed_nxt = 1'b0;
        flip_nxt  = !flip_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready) begin
      s1_item_r.sample_value <= in_if.sample_value;
      s1_item_r.now.hours    <= in_if.now_hours;
      s1_item_r.now.minutes  <= in_if.now_minutes;
      s1_item_r.now.seconds  <= in_if.now_seconds;
      s1_item_r.now.micros   <= in_if.now_micros;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      held_r          <= '0;
      armed_r         <= 1'b0;
      start_r         <= '0;
      flip_r          <= 1'b0;
      out_valid_r     <= 1'b0;
      out_timed_out_r <= 1'b0;
    end else begin
      s1_valid_r      <= s1_valid_nxt;
      held_r          <= held_nxt;
      armed_r         <= armed_nxt;
      start_r         <= start_nxt;
      flip_r          <= flip_nxt;
      out_valid_r     <= out_valid_nxt;
      out_timed_out_r <= out_timed_out_nxt;
    end
  end

  // A timeout toggles the flip bit and leaves the detector disarmed.
  a_fire_toggles: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && dec.fire) |=> (flip_r != $past(flip_r)) && !armed_r)
    else $error("timeout did not toggle the flip bit and disarm");

  // The flip bit moves only on a timeout.
  a_flip_only_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_go && dec.fire) |=> $stable(flip_r))
    else $error("flip bit changed without a timeout");

  // A full pipeline with a stalled result side takes no new sample.
  a_full_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_if.ready) |-> !in_if.ready)
    else $error("sample accepted while pipeline full");

  // Every evaluated sample yields a result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_valid_r && (out_if.timed_out == $past(dec.fire)))
    else $error("evaluated sample produced no matching result");

endmodule
